[sv/gbfp_pkg.sv]
// Shared types and constants for the GNSS binary frame parser.
// No dependencies; every other file imports this package.
package gbfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // request and result kind codes
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;
    localparam logic RK_FRAME = 1'b0;
    localparam logic RK_READ  = 1'b1;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN1,
        PH_LEN2,
        PH_PAYLOAD,
        PH_CK1,
        PH_CK2
    } t_phase;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] frame_class;
        logic [7:0] frame_id;
        logic [8:0] frame_length;
        logic [7:0] read_data;
    } t_out_item;

    // parser to top: checksum-good frame found on this byte
    typedef struct packed {
        logic       ok;
        logic [7:0] frame_class;
        logic [7:0] frame_id;
        logic [8:0] frame_length;
    } t_frame_info;

endpackage

[sv/gbfp_store.sv]
// Payload store: single-port-per-cycle byte memory with registered read data.
// Depends on gbfp_pkg. Entries above the high-water mark read as zero.
module gbfp_store #(
    parameter int MAX_PAYLOAD = gbfp_pkg::MAX_PAYLOAD_DEF,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int CW = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [7:0]    i_rd_idx,
    output logic [7:0]    o_rd_data
);
    import gbfp_pkg::*;

    localparam int XW = (CW > 8) ? CW : 8;

    logic [7:0]    r_mem [MAX_PAYLOAD];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_hwm;
    logic [CW-1:0] wr_next;
    logic [AW-1:0] rd_addr;
    logic          rd_hit;

    // frames fill from index 0 upward, so everything below the mark was written
    assign wr_next = CW'(i_wr_addr) + CW'(1);
    assign rd_addr = AW'(i_rd_idx);
    assign rd_hit  = XW'(i_rd_idx) < XW'(r_hwm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hwm <= '0;
        end else if (i_wr_en && (wr_next > r_hwm)) begin
            r_hwm <= wr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= rd_hit ? r_mem[rd_addr] : 8'd0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/gbfp_parser.sv]
// Frame state machine with running Fletcher-8 sums.
// Depends on gbfp_pkg; drives the payload store write port.
module gbfp_parser #(
    parameter int MAX_PAYLOAD = gbfp_pkg::MAX_PAYLOAD_DEF,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int CW = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [7:0]            i_byte,
    output gbfp_pkg::t_frame_info o_frame,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr
);
    import gbfp_pkg::*;

    t_phase        r_phase, n_phase;
    logic [7:0]    r_class, n_class;
    logic [7:0]    r_id, n_id;
    logic [15:0]   r_len, n_len;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_sum_a, n_sum_a;
    logic [7:0]    r_sum_b, n_sum_b;
    logic [7:0]    r_exp_a, n_exp_a;

    logic [7:0]    add_a;
    logic [7:0]    add_b;
    logic [15:0]   len_full;
    logic          len_fits;
    logic [CW-1:0] cnt_inc;
    logic          last_payload;

    function automatic logic XW_LT(input logic [CW-1:0] cnt);
        XW_LT = 17'(cnt) < 17'(MAX_PAYLOAD);
    endfunction

    assign add_a        = r_sum_a + i_byte;
    assign add_b        = r_sum_b + add_a;
    assign len_full     = {i_byte, r_len[7:0]};
    assign len_fits     = {1'b0, len_full} <= 17'(MAX_PAYLOAD);
    assign cnt_inc      = r_cnt + CW'(1);
    assign last_payload = 16'(cnt_inc) >= r_len;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_SYNC1: begin
                if (i_byte == SYNC_FIRST) n_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                // a bad second sync is not retried as a first sync
                n_phase = (i_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: n_phase = PH_ID;
            PH_ID:    n_phase = PH_LEN1;
            PH_LEN1:  n_phase = PH_LEN2;
            PH_LEN2: begin
                if (!len_fits) begin
                    n_phase = PH_SYNC1;
                end else if (len_full == 16'd0) begin
                    n_phase = PH_CK1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (last_payload) n_phase = PH_CK1;
            end
            PH_CK1:  n_phase = PH_CK2;
            PH_CK2:  n_phase = PH_SYNC1;
            default: n_phase = PH_SYNC1;
        endcase
    end

    // datapath registers and outputs
    always_comb begin
        n_class   = r_class;
        n_id      = r_id;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_exp_a   = r_exp_a;
        o_wr_en   = 1'b0;
        o_wr_addr = AW'(r_cnt);
        o_frame   = '{ok: 1'b0, frame_class: r_class, frame_id: r_id,
                      frame_length: r_len[8:0]};
        case (r_phase)
            PH_SYNC2: begin
                if (i_byte == SYNC_SECOND) begin
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                end
            end
            PH_CLASS: begin
                n_class = i_byte;
                n_sum_a = add_a;
                n_sum_b = add_b;
            end
            PH_ID: begin
                n_id    = i_byte;
                n_sum_a = add_a;
                n_sum_b = add_b;
            end
            PH_LEN1: begin
                n_len   = {8'd0, i_byte};
                n_sum_a = add_a;
                n_sum_b = add_b;
            end
            PH_LEN2: begin
                n_len   = len_full;
                n_sum_a = add_a;
                n_sum_b = add_b;
                if (len_fits) n_cnt = '0;
            end
            PH_PAYLOAD: begin
                o_wr_en = i_en && (XW_LT(r_cnt));
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_cnt   = cnt_inc;
            end
            PH_CK1: n_exp_a = i_byte;
            PH_CK2: begin
                // qualified by the top, which also decides whether the beat advances
                o_frame.ok = (r_sum_a == r_exp_a) && (r_sum_b == i_byte);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_class <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_exp_a <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_exp_a <= n_exp_a;
        end
    end

endmodule

[sv/gnss_binary_frame_parser.sv]
// Top level of the GNSS binary frame parser: input register, parser, store, result register.
// Depends on gbfp_pkg, gbfp_parser and gbfp_store.

// Takes one beat per cycle unless a result is stalled in the result register, either a
// received byte or a payload read request. Each beat is registered in the input register,
// is processed there, and its result (if any) lands in the result register, from which it
// is offered; read data comes straight from the store's registered read port, beside the
// result register.
// Frames are 0xB5 0x62, class, id, 16-bit little-endian length, payload, checksum A/B;
// a checksum-good frame produces one frame result, a bad one produces nothing. Reads
// always produce one result; entries never written since reset read as zero. The store
// needs no clearing pass: it is usable as soon as reset is released.
module gnss_binary_frame_parser #(
    parameter int MAX_PAYLOAD = gbfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gbfp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gbfp_pkg::t_out_item o_out_data
);
    import gbfp_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic        r_s1_vld;
    t_in_item    r_s1;
    logic        r_out_vld;
    t_out_item   r_out;

    t_frame_info frame;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]  rd_data;
    logic        has_res;
    logic        s1_adv;
    logic        s1_fire;
    logic        is_read;

    assign is_read    = r_s1.req_type == REQ_READ;
    assign has_res    = is_read || frame.ok;
    assign s1_adv     = !has_res || !r_out_vld || i_out_ready;
    assign s1_fire    = r_s1_vld && s1_adv;
    assign o_in_ready = !r_s1_vld || s1_adv;

    gbfp_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (s1_fire && !is_read),
        .i_byte    (r_s1.rx_byte),
        .o_frame   (frame),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr)
    );

    gbfp_store #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_s1.rx_byte),
        .i_rd_en   (s1_fire && is_read),
        .i_rd_idx  (r_s1.read_index),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire && has_res) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // read data comes from the store's own output register
    always_ff @(posedge i_clk) begin
        if (s1_fire && has_res) begin
            if (is_read) begin
                r_out <= '{result_kind: RK_READ, frame_class: 8'd0, frame_id: 8'd0,
                           frame_length: 9'd0, read_data: 8'd0};
            end else begin
                r_out <= '{result_kind: RK_FRAME, frame_class: frame.frame_class,
                           frame_id: frame.frame_id, frame_length: frame.frame_length,
                           read_data: 8'd0};
            end
        end
    end

    assign o_out_valid = r_out_vld;
    always_comb begin
        o_out_data = r_out;
        o_out_data.read_data = (r_out.result_kind == RK_READ) ? rd_data : 8'd0;
    end

    // a pending result is never dropped while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");

    // a blocked item stays in the input register untouched
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> (r_s1_vld && $stable(r_s1)))
        else $error("input register changed while blocked");

    // parser never writes the store while a read request is being processed
    a_no_wr_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && is_read) |-> !wr_en)
        else $error("store write during read request");

endmodule
